// ===== rtl/bsoc_pkg.sv =====
// Shared types and constants for the battery state-of-charge lookup block.
// Used by bsoc_bp_mem, bsoc_divider and battery_soc_lut_interpolator.
package bsoc_pkg;

    // Item command codes
    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_LOOKUP = 1'b1
    } t_cmd;

    // Configuration register indexes
    typedef enum logic {
        CFG_ACTIVE_BREAKPOINTS  = 1'b0,
        CFG_INTERNAL_RESISTANCE = 1'b1
    } t_cfg_reg;

    localparam int CFG_DATA_W   = 16;
    localparam int COUNT_W      = 5;
    localparam int VOLT_W       = 16;
    localparam int PCT_W        = 10;
    localparam int CURR_W       = 20;
    localparam int SAG_W        = 16;

    localparam logic [PCT_W-1:0]   PCT_LIMIT    = 10'd1000;
    localparam logic [COUNT_W-1:0] MIN_POINTS   = 5'd2;
    localparam logic [VOLT_W-1:0]  COMP_DIVISOR = 16'd10000;

    // Shared divider geometry: 36-bit dividend, 16-bit divisor, one bit per cycle
    localparam int DIV_DIVIDEND_W = 36;
    localparam int DIV_DIVISOR_W  = 16;
    localparam int DIV_CNT_W      = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 6'd36;

    // Saturation bounds for the compensation quotient
    localparam logic [DIV_DIVIDEND_W-1:0] SAG_POS_MAX = 36'd32767;
    localparam logic [DIV_DIVIDEND_W-1:0] SAG_NEG_MAX = 36'd32768;

    typedef struct packed {
        t_cmd                      cmd;
        logic [3:0]                entry_index;
        logic [VOLT_W-1:0]         entry_voltage;
        logic [PCT_W-1:0]          entry_percent;
        logic [VOLT_W-1:0]         pack_voltage;
        logic signed [CURR_W-1:0]  pack_current;
    } t_in_item;

    typedef struct packed {
        logic [PCT_W-1:0]          charge_percent;
        logic signed [SAG_W-1:0]   sag_compensation;
        logic                      table_ok;
    } t_out_item;

    // One breakpoint as held in the table memory
    typedef struct packed {
        logic [VOLT_W-1:0] voltage;
        logic [PCT_W-1:0]  percent;
    } t_bp_entry;

    typedef struct packed {
        logic                       start;
        logic [DIV_DIVIDEND_W-1:0]  dividend;
        logic [DIV_DIVISOR_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic                       done;
        logic [DIV_DIVIDEND_W-1:0]  quotient;
    } t_div_rsp;

endpackage

// ===== rtl/battery_soc_lut_interpolator.sv =====
// Battery state-of-charge lookup over a piecewise-linear breakpoint table.
// Top level: sequencer around bsoc_bp_mem and bsoc_divider, uses bsoc_pkg.
//
// A write item stores one breakpoint and gives no result.
// A lookup item walks the active breakpoints once through the table's single
// read port (one entry per cycle), checking the ordering and finding the
// segment. It then runs the interpolation divide and the IR-drop divide on one
// shared divider, which retires one quotient bit per cycle over 36 steps. After
// it takes a lookup, the input stays not ready until the result is handed to
// the output register. When the voltage clamps at a table end, or the ordering
// is bad, the interpolation divide is skipped. When the breakpoint count is out
// of range, the walk is skipped too. A finished result waits in an output
// register, so the next item may be taken before the result is collected. Only
// a second result that meets an uncollected one stalls, and it adds the cycles
// of that wait. Reset empties the table at once through per-entry valid bits;
// no clearing pass follows reset. Configuration is always ready.
module battery_soc_lut_interpolator #(
    parameter int MAX_POINTS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bsoc_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bsoc_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  bsoc_pkg::t_cfg_reg  i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    import bsoc_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_WALK = 7'b0000010,
        S_SEL  = 7'b0000100,
        S_PMUL = 7'b0001000,
        S_CMUL = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state                     r_state, n_state;
    logic [COUNT_W-1:0]         r_active;
    logic [VOLT_W-1:0]          r_resist;
    logic                       r_out_valid;
    t_out_item                  r_out;

    logic [VOLT_W-1:0]          r_pack_v;
    logic [CURR_W-1:0]          r_mag;
    logic                       r_neg;
    logic [COUNT_W-1:0]         r_n;
    logic [AW-1:0]              r_k;
    logic                       r_cnt_ok;
    logic                       r_bad;
    logic                       r_found;
    logic                       r_ok;
    logic                       r_comp_phase;
    t_bp_entry                  r_first;
    t_bp_entry                  r_prev;
    t_bp_entry                  r_seg_hi;
    t_bp_entry                  r_seg_lo;
    logic [PCT_W-1:0]           r_pct;
    logic [SAG_W-1:0]           r_sag;

    logic                       in_acc;
    logic                       wr_en;
    t_bp_entry                  wr_data;
    logic [AW-1:0]              rd_addr;
    t_bp_entry                  rd_data;
    t_div_req                   div_req;
    t_div_rsp                   div_rsp;
    logic                       cnt_ok;
    logic [CURR_W-1:0]          cur_mag;
    logic                       walk_first;
    logic                       walk_last;
    logic                       walk_bad;
    logic                       walk_hit;
    logic                       tbl_ok;
    logic [VOLT_W-1:0]          seg_off;
    logic [VOLT_W-1:0]          seg_dv;
    logic [PCT_W-1:0]           seg_dp;
    logic [VOLT_W+PCT_W-1:0]    seg_prod;
    logic [DIV_DIVIDEND_W-1:0]  comp_prod;
    logic [SAG_W:0]             neg_mag;
    logic [SAG_W-1:0]           sag_sat;
    logic                       out_load;

    // Handshakes
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // Breakpoint write path with percent clamp
    assign wr_en = in_acc && (i_in_data.cmd == CMD_WRITE)
                   && (int'(i_in_data.entry_index) < MAX_POINTS);
    assign wr_data.voltage = i_in_data.entry_voltage;
    assign wr_data.percent = (i_in_data.entry_percent > PCT_LIMIT) ? PCT_LIMIT
                                                                   : i_in_data.entry_percent;
    assign rd_addr = (r_state == S_WALK) ? AW'(r_k + 1'b1) : '0;

    bsoc_bp_mem #(
        .MAX_POINTS (MAX_POINTS),
        .AW         (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'(i_in_data.entry_index)),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Lookup setup: count range and current magnitude
    assign cnt_ok  = (r_active >= MIN_POINTS) && (int'(r_active) <= MAX_POINTS);
    assign cur_mag = i_in_data.pack_current[CURR_W-1]
                     ? CURR_W'(~i_in_data.pack_current + 1'b1)
                     : CURR_W'(i_in_data.pack_current);

    // Table walk: ordering check and segment search on the entry just read
    assign walk_first = (r_k == '0);
    assign walk_last  = (int'(r_k) == int'(r_n) - 1);
    assign walk_bad   = !walk_first && ((rd_data.voltage >= r_prev.voltage)
                                        || (rd_data.percent > r_prev.percent));
    assign walk_hit   = !walk_first && !r_found && (r_pack_v >= rd_data.voltage);
    assign tbl_ok     = r_cnt_ok && !r_bad;

    // Operands for the two divides
    assign seg_off   = r_pack_v - r_seg_lo.voltage;
    assign seg_dv    = r_seg_hi.voltage - r_seg_lo.voltage;
    assign seg_dp    = r_seg_hi.percent - r_seg_lo.percent;
    assign seg_prod  = seg_off * seg_dp;
    assign comp_prod = DIV_DIVIDEND_W'(r_mag) * DIV_DIVIDEND_W'(r_resist);

    always_comb begin
        div_req.start    = (r_state == S_PMUL) || (r_state == S_CMUL);
        div_req.dividend = (r_state == S_PMUL) ? DIV_DIVIDEND_W'(seg_prod) : comp_prod;
        div_req.divisor  = (r_state == S_PMUL) ? seg_dv : COMP_DIVISOR;
    end

    bsoc_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Saturate the signed compensation
    always_comb begin
        neg_mag = (div_rsp.quotient > SAG_NEG_MAX) ? (SAG_W+1)'(SAG_NEG_MAX)
                                                   : (SAG_W+1)'(div_rsp.quotient);
        if (r_neg) begin
            sag_sat = SAG_W'((SAG_W+1)'(0) - neg_mag);
        end else if (div_rsp.quotient > SAG_POS_MAX) begin
            sag_sat = SAG_W'(SAG_POS_MAX);
        end else begin
            sag_sat = div_rsp.quotient[SAG_W-1:0];
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in_data.cmd == CMD_LOOKUP)) begin
                    n_state = cnt_ok ? S_WALK : S_CMUL;
                end
            end
            S_WALK: begin
                if (walk_last) begin
                    n_state = S_SEL;
                end
            end
            S_SEL: begin
                if (tbl_ok && (r_pack_v < r_first.voltage) && r_found) begin
                    n_state = S_PMUL;
                end else begin
                    n_state = S_CMUL;
                end
            end
            S_PMUL: n_state = S_DIV;
            S_CMUL: n_state = S_DIV;
            S_DIV: begin
                if (div_rsp.done) begin
                    n_state = r_comp_phase ? S_DONE : S_CMUL;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state, configuration registers and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_resist    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_ACTIVE_BREAKPOINTS:  r_active <= i_cfg_data[COUNT_W-1:0];
                    CFG_INTERNAL_RESISTANCE: r_resist <= i_cfg_data;
                    default: ;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        // Latch the lookup item
        if (in_acc) begin
            r_pack_v <= i_in_data.pack_voltage;
            r_mag    <= cur_mag;
            r_neg    <= i_in_data.pack_current[CURR_W-1];
            r_n      <= r_active;
            r_cnt_ok <= cnt_ok;
            r_k      <= '0;
            r_bad    <= 1'b0;
            r_found  <= 1'b0;
            r_ok     <= 1'b0;
            r_pct    <= '0;
        end

        // Advance through the table
        if (r_state == S_WALK) begin
            r_k    <= AW'(r_k + 1'b1);
            r_prev <= rd_data;
            if (walk_first) begin
                r_first <= rd_data;
            end
            if (walk_bad) begin
                r_bad <= 1'b1;
            end
            if (walk_hit) begin
                r_found  <= 1'b1;
                r_seg_hi <= r_prev;
                r_seg_lo <= rd_data;
            end
        end

        // Pick the clamped or interpolated case
        if (r_state == S_SEL) begin
            r_ok <= tbl_ok;
            if (!tbl_ok) begin
                r_pct <= '0;
            end else if (r_pack_v >= r_first.voltage) begin
                r_pct <= r_first.percent;
            end else if (!r_found) begin
                r_pct <= r_prev.percent;
            end
        end

        if (r_state == S_PMUL) begin
            r_comp_phase <= 1'b0;
        end
        if (r_state == S_CMUL) begin
            r_comp_phase <= 1'b1;
        end

        // Collect divider results
        if ((r_state == S_DIV) && div_rsp.done) begin
            if (r_comp_phase) begin
                r_sag <= sag_sat;
            end else begin
                r_pct <= r_seg_lo.percent + div_rsp.quotient[PCT_W-1:0];
            end
        end

        // Hand the result to the output register
        if (out_load) begin
            r_out.charge_percent   <= r_pct;
            r_out.sag_compensation <= r_sag;
            r_out.table_ok         <= r_ok;
        end
    end

endmodule

// ===== rtl/bsoc_bp_mem.sv =====
// Breakpoint table memory: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero. Uses bsoc_pkg.
module bsoc_bp_mem #(
    parameter int MAX_POINTS = 16,
    parameter int AW         = $clog2(MAX_POINTS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr_en,
    input  logic [AW-1:0]       i_wr_addr,
    input  bsoc_pkg::t_bp_entry i_wr_data,
    input  logic [AW-1:0]       i_rd_addr,
    output bsoc_pkg::t_bp_entry o_rd_data
);
    import bsoc_pkg::*;

    t_bp_entry                r_mem [MAX_POINTS];
    logic [MAX_POINTS-1:0]    r_valid;
    t_bp_entry                r_rd_data;
    logic                     r_rd_valid;

    // Mark written entries; reset empties the whole table at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    // Write and read the storage array
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

// ===== rtl/bsoc_divider.sv =====
// Shared restoring divider, one quotient bit per cycle, 36-bit dividend.
// Serves both the interpolation and the compensation divide. Uses bsoc_pkg.
module bsoc_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bsoc_pkg::t_div_req i_req,
    output bsoc_pkg::t_div_rsp o_rsp
);
    import bsoc_pkg::*;

    logic                       r_busy;
    logic                       r_done;
    logic [DIV_CNT_W-1:0]       r_cnt;
    logic [DIV_DIVIDEND_W-1:0]  r_quo;
    logic [DIV_DIVISOR_W-1:0]   r_rem;
    logic [DIV_DIVISOR_W-1:0]   r_den;

    logic [DIV_DIVISOR_W:0]     rem_sh;
    logic [DIV_DIVISOR_W:0]     diff;
    logic                       ge;
    logic [DIV_DIVISOR_W-1:0]   n_rem;

    // Trial subtract of the shifted partial remainder
    always_comb begin
        rem_sh = {r_rem, r_quo[DIV_DIVIDEND_W-1]};
        diff   = rem_sh - {1'b0, r_den};
        ge     = rem_sh >= {1'b0, r_den};
        n_rem  = ge ? diff[DIV_DIVISOR_W-1:0] : rem_sh[DIV_DIVISOR_W-1:0];
    end

    // Step counter and completion pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_STEPS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Load operands, then shift one quotient bit in per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_DIVIDEND_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule
